### rtl/core/sbt_pkg.sv
// ----------------------------------------------------------------------------
// S-expression byte tokenizer package
// Shared constants, character codes, token kinds and result types.
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int OUT_BITS    = 64;
    localparam int ACC_BITS    = VALUE_BITS + 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int FIELD_BITS  = 2 * OUT_BITS + 8 + 8 + 2;
    localparam int TDATA_BITS  = ((FIELD_BITS + 7) / 8) * 8;
    localparam int TDATA_PAD   = TDATA_BITS - FIELD_BITS;

    localparam logic [VALUE_BITS-1:0] TOP_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_QUESTION   = 8'h3F;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] COUNT_MAX     = 8'hFF;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_FRAC_SIGN,
        MODE_FRAC,
        MODE_SKIP,
        MODE_STR,
        MODE_STR_ESC,
        MODE_SYM
    } mode_t;

    typedef enum logic [3:0] {
        KIND_INT       = 4'd0,
        KIND_FLOAT     = 4'd1,
        KIND_STR_CHAR  = 4'd2,
        KIND_STR_END   = 4'd3,
        KIND_SYM_CHAR  = 4'd4,
        KIND_SYM_END   = 4'd5,
        KIND_LPAREN    = 4'd6,
        KIND_RPAREN    = 4'd7,
        KIND_DOT       = 4'd8,
        KIND_END       = 4'd9,
        KIND_ERROR     = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        ERR_TOO_BIG,
        ERR_ESC_AT_END,
        ERR_OPEN_STRING,
        ERR_BAD_SYMBOL
    } err_t;

    typedef struct packed {
        kind_t                kind;
        logic [OUT_BITS-1:0]  value;
        logic [OUT_BITS-1:0]  fraction;
        logic [7:0]           fraction_digits;
        logic [7:0]           character;
        err_t                 error_code;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    slot0;
        result_t    slot1;
    } push_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sym_char(logic [7:0] c);
        return is_digit(c) || ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) || (c == CH_QUESTION) ||
               (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_UNDERSCORE);
    endfunction

    function automatic result_t make_result(kind_t k, logic [OUT_BITS-1:0] v,
                                            logic [OUT_BITS-1:0] f, logic [7:0] dg,
                                            logic [7:0] ch, err_t e);
        result_t r;
        r.kind            = k;
        r.value           = v;
        r.fraction        = f;
        r.fraction_digits = dg;
        r.character       = ch;
        r.error_code      = e;
        r.last            = 1'b0;
        return r;
    endfunction

    function automatic logic [OUT_BITS-1:0] signed_out(logic [VALUE_BITS-1:0] m, logic neg);
        logic [VALUE_BITS-1:0] t;
        t = neg ? (~m + 1'b1) : m;
        return OUT_BITS'(signed'(t));
    endfunction

endpackage

### rtl/core/sbt_lexer.sv
// ----------------------------------------------------------------------------
// S-expression lexer core
// Holds the lexer state and turns one accepted byte into up to two results.
// ----------------------------------------------------------------------------
module sbt_lexer (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_eoi,
    output sbt_pkg::push_t push
);
    import sbt_pkg::*;

    mode_t                 mode_reg, mode_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [VALUE_BITS-1:0] int_part_reg, int_part_next;
    logic                  frac_neg_reg, frac_neg_next;
    logic [7:0]            count_reg, count_next;

    logic                  accept;
    logic                  digit_neg;
    logic [ACC_BITS-1:0]   acc_sum;
    logic [ACC_BITS-1:0]   limit;
    logic                  digit_ok;
    logic                  in_is_digit;

    logic                  idle_valid;
    result_t               idle_res;
    mode_t                 idle_mode;
    logic                  idle_num;

    logic                  a_valid, b_valid, use_idle;
    result_t               a_res, b_res;
    result_t               end_res, int_res, float_res, too_big_res;

    assign accept      = in_valid && in_ready;
    assign in_is_digit = is_digit(in_byte);

    // Shared digit unit: acc * 10 + d, checked against the signed limit.
    assign digit_neg = (mode_reg == MODE_INT) ? neg_reg : frac_neg_reg;
    assign acc_sum   = ACC_BITS'({acc_reg, 3'b000}) + ACC_BITS'({acc_reg, 1'b0}) +
                       ACC_BITS'(in_byte[3:0]);
    assign limit     = digit_neg ? ACC_BITS'(TOP_BIT) : ACC_BITS'(TOP_BIT - 1'b1);
    assign digit_ok  = acc_sum <= limit;

    assign end_res     = make_result(KIND_END, '0, '0, '0, '0, ERR_TOO_BIG);
    assign too_big_res = make_result(KIND_ERROR, '0, '0, '0, '0, ERR_TOO_BIG);
    assign int_res     = make_result(KIND_INT, signed_out(acc_reg, neg_reg), '0, '0, '0,
                                     ERR_TOO_BIG);
    assign float_res   = make_result(KIND_FLOAT, OUT_BITS'(signed'(int_part_reg)),
                                     signed_out(acc_reg, frac_neg_reg), count_reg, '0,
                                     ERR_TOO_BIG);

    always_comb begin
        idle_valid = 1'b0;
        idle_res   = make_result(KIND_END, '0, '0, '0, '0, ERR_TOO_BIG);
        idle_mode  = MODE_IDLE;
        idle_num   = 1'b0;
        if ((in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_CR) ||
            (in_byte == CH_LF)) begin
            idle_mode = MODE_IDLE;
        end else if (in_is_digit || (in_byte == CH_MINUS)) begin
            idle_num  = 1'b1;
            idle_mode = MODE_INT;
        end else if (in_byte == CH_QUOTE) begin
            idle_mode = MODE_STR;
        end else if (in_byte == CH_LPAREN) begin
            idle_valid = 1'b1;
            idle_res   = make_result(KIND_LPAREN, '0, '0, '0, '0, ERR_TOO_BIG);
        end else if (in_byte == CH_RPAREN) begin
            idle_valid = 1'b1;
            idle_res   = make_result(KIND_RPAREN, '0, '0, '0, '0, ERR_TOO_BIG);
        end else if (in_byte == CH_DOT) begin
            idle_valid = 1'b1;
            idle_res   = make_result(KIND_DOT, '0, '0, '0, '0, ERR_TOO_BIG);
        end else if (is_sym_char(in_byte)) begin
            idle_valid = 1'b1;
            idle_res   = make_result(KIND_SYM_CHAR, '0, '0, '0, in_byte, ERR_TOO_BIG);
            idle_mode  = MODE_SYM;
        end else begin
            idle_valid = 1'b1;
            idle_res   = make_result(KIND_ERROR, '0, '0, '0, '0, ERR_BAD_SYMBOL);
        end
    end

    always_comb begin
        mode_next     = mode_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        int_part_next = int_part_reg;
        frac_neg_next = frac_neg_reg;
        count_next    = count_reg;
        a_valid       = 1'b0;
        a_res         = end_res;
        b_valid       = 1'b0;
        b_res         = end_res;
        use_idle      = 1'b0;
        unique case (mode_reg) inside
            MODE_INT: begin
                if (in_eoi) begin
                    a_valid   = 1'b1;
                    a_res     = int_res;
                    b_valid   = 1'b1;
                    mode_next = MODE_IDLE;
                end else if (in_is_digit) begin
                    if (digit_ok) begin
                        acc_next = acc_sum[VALUE_BITS-1:0];
                    end else begin
                        a_valid   = 1'b1;
                        a_res     = too_big_res;
                        mode_next = MODE_SKIP;
                    end
                end else if (in_byte == CH_DOT) begin
                    int_part_next = VALUE_BITS'(signed_out(acc_reg, neg_reg));
                    acc_next      = '0;
                    count_next    = '0;
                    frac_neg_next = 1'b0;
                    mode_next     = MODE_FRAC_SIGN;
                end else begin
                    a_valid  = 1'b1;
                    a_res    = int_res;
                    use_idle = 1'b1;
                end
            end
            MODE_FRAC_SIGN, MODE_FRAC: begin
                if (in_eoi) begin
                    a_valid   = 1'b1;
                    a_res     = float_res;
                    b_valid   = 1'b1;
                    mode_next = MODE_IDLE;
                end else if ((mode_reg == MODE_FRAC_SIGN) &&
                             ((in_byte == CH_PLUS) || (in_byte == CH_MINUS))) begin
                    frac_neg_next = (in_byte == CH_MINUS);
                    mode_next     = MODE_FRAC;
                end else if (in_is_digit) begin
                    if (digit_ok) begin
                        acc_next  = acc_sum[VALUE_BITS-1:0];
                        mode_next = MODE_FRAC;
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + 8'd1;
                        end
                    end else begin
                        a_valid   = 1'b1;
                        a_res     = too_big_res;
                        mode_next = MODE_SKIP;
                    end
                end else begin
                    a_valid  = 1'b1;
                    a_res    = float_res;
                    use_idle = 1'b1;
                end
            end
            MODE_SKIP: begin
                if (in_eoi) begin
                    b_valid   = 1'b1;
                    mode_next = MODE_IDLE;
                end else if (!in_is_digit) begin
                    use_idle = 1'b1;
                end
            end
            MODE_STR: begin
                mode_next = MODE_IDLE;
                b_valid   = 1'b1;
                if (in_eoi) begin
                    b_res = make_result(KIND_ERROR, '0, '0, '0, '0, ERR_OPEN_STRING);
                end else if (in_byte == CH_QUOTE) begin
                    b_res = make_result(KIND_STR_END, '0, '0, '0, '0, ERR_TOO_BIG);
                end else if (in_byte == CH_BACKSLASH) begin
                    b_valid   = 1'b0;
                    mode_next = MODE_STR_ESC;
                end else begin
                    b_res     = make_result(KIND_STR_CHAR, '0, '0, '0, in_byte, ERR_TOO_BIG);
                    mode_next = MODE_STR;
                end
            end
            MODE_STR_ESC: begin
                b_valid = 1'b1;
                if (in_eoi) begin
                    b_res     = make_result(KIND_ERROR, '0, '0, '0, '0, ERR_ESC_AT_END);
                    mode_next = MODE_IDLE;
                end else begin
                    b_res     = make_result(KIND_STR_CHAR, '0, '0, '0, in_byte, ERR_TOO_BIG);
                    mode_next = MODE_STR;
                end
            end
            MODE_SYM: begin
                if (in_eoi) begin
                    a_valid   = 1'b1;
                    a_res     = make_result(KIND_SYM_END, '0, '0, '0, '0, ERR_TOO_BIG);
                    b_valid   = 1'b1;
                    mode_next = MODE_IDLE;
                end else if (is_sym_char(in_byte)) begin
                    b_valid = 1'b1;
                    b_res   = make_result(KIND_SYM_CHAR, '0, '0, '0, in_byte, ERR_TOO_BIG);
                end else begin
                    a_valid  = 1'b1;
                    a_res    = make_result(KIND_SYM_END, '0, '0, '0, '0, ERR_TOO_BIG);
                    use_idle = 1'b1;
                end
            end
            default: begin
                if (in_eoi) begin
                    b_valid   = 1'b1;
                    mode_next = MODE_IDLE;
                end else begin
                    use_idle = 1'b1;
                end
            end
        endcase

        if (use_idle) begin
            b_valid   = idle_valid;
            b_res     = idle_res;
            mode_next = idle_mode;
            if (idle_num) begin
                neg_next      = (in_byte == CH_MINUS);
                acc_next      = in_is_digit ? VALUE_BITS'(in_byte[3:0]) : '0;
                frac_neg_next = 1'b0;
                count_next    = '0;
            end
        end
    end

    always_comb begin
        push.slot0      = a_valid ? a_res : b_res;
        push.slot1      = b_res;
        push.slot0.last = !(a_valid && b_valid);
        push.slot1.last = 1'b1;
        push.count      = accept ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            neg_reg      <= 1'b0;
            acc_reg      <= '0;
            int_part_reg <= '0;
            frac_neg_reg <= 1'b0;
            count_reg    <= '0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            neg_reg      <= neg_next;
            acc_reg      <= acc_next;
            int_part_reg <= int_part_next;
            frac_neg_reg <= frac_neg_next;
            count_reg    <= count_next;
        end
    end

endmodule

### rtl/core/sbt_out_queue.sv
// ----------------------------------------------------------------------------
// S-expression tokenizer result queue
// Small register queue that takes up to two results per cycle and gives one on pop_ready.
// ----------------------------------------------------------------------------
module sbt_out_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sbt_pkg::push_t              push,
    input  logic                        pop_ready,
    output sbt_pkg::result_t            head,
    output logic                        head_valid,
    output logic [sbt_pkg::LEVEL_BITS-1:0] level
);
    import sbt_pkg::*;

    result_t               entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;
    logic [QUEUE_AW-1:0]   wr_ptr_plus1;
    logic                  pop;

    assign head_valid   = (level_reg != '0);
    assign head         = entries_reg[rd_ptr_reg];
    assign level        = level_reg;
    assign pop          = head_valid && pop_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + QUEUE_AW'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + QUEUE_AW'(pop);
    assign level_next   = level_reg + LEVEL_BITS'(push.count) - LEVEL_BITS'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push.slot0;
        end
        if (push.count == 2'd2) begin
            entries_reg[wr_ptr_plus1] <= push.slot1;
        end
    end

endmodule

### rtl/core/sexpr_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// S-expression byte tokenizer
// Tokenizes a byte stream into numbers, strings, symbols and punctuation.
//
//   Channel  Direction  tdata                 tuser          tlast
//   s_axis   in         byte_req [7:0]        end_of_input   -
//   m_axis   out        value, fraction,      kind [3:0]     last
//                       digits, char, error
//
// Each byte yields zero, one or two results.
// A four-entry result queue takes a new byte whenever at least two entries
// are free, so single-result bytes flow at one per cycle while m_axis is ready.
// Reset clears the lexer state and empties the queue.
// A stalled result channel fills the queue and then holds s_axis_tready low.
// ----------------------------------------------------------------------------
module sexpr_byte_tokenizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // byte_req
    input  logic                          s_axis_tuser,  // end_of_input
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // value, fraction, fraction_digits, character, error_code, zero pad
    output logic [sbt_pkg::TDATA_BITS-1:0] m_axis_tdata,
    output logic [3:0]                    m_axis_tuser,  // kind
    output logic                          m_axis_tlast
);
    import sbt_pkg::*;

    push_t                 push;
    result_t               head;
    logic                  head_valid;
    logic [LEVEL_BITS-1:0] queue_level;

    assign s_axis_tready = (queue_level <= LEVEL_BITS'(QUEUE_DEPTH - 2));

    sbt_lexer u_lexer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_eoi   (s_axis_tuser),
        .push     (push)
    );

    sbt_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop_ready  (m_axis_tready),
        .head       (head),
        .head_valid (head_valid),
        .level      (queue_level)
    );

    assign m_axis_tvalid = head_valid;
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {{TDATA_PAD{1'b0}}, head.error_code, head.character,
                            head.fraction_digits, head.fraction, head.value};

`ifndef NO_ASSERTIONS
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_level <= LEVEL_BITS'(QUEUE_DEPTH))
        else $error("Result queue level exceeds its depth.");

    a_push_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> (s_axis_tvalid && s_axis_tready))
        else $error("Results were pushed without an input transfer.");

    a_no_loss_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (queue_level >= $past(queue_level)))
        else $error("Result queue lost an entry while the output was stalled.");
`endif

endmodule
